FILE: rtl/sida_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
package sida_pkg;

	localparam int unsigned DIGIT_BITS = 4;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT  = 4'd5;
	localparam logic [DIGIT_BITS-1:0] DABBLE_OFFSET = 4'd3;

endpackage

FILE: rtl/sida_dabble.sv
// Add-3 correction applied to each BCD digit of 5 or more before one shift of double dabble.
module sida_dabble #(
	parameter int DIGITS = 10
) (
	input  logic [DIGITS*sida_pkg::DIGIT_BITS-1:0] bcd,
	output logic [DIGITS*sida_pkg::DIGIT_BITS-1:0] adjusted
);
	import sida_pkg::*;

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd[d*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
				adjusted[d*DIGIT_BITS +: DIGIT_BITS] =
					bcd[d*DIGIT_BITS +: DIGIT_BITS] + DABBLE_OFFSET;
			end else begin
				adjusted[d*DIGIT_BITS +: DIGIT_BITS] = bcd[d*DIGIT_BITS +: DIGIT_BITS];
			end
		end
	end

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, top level.
//
// One word on the slave channel carries a signed two's complement value of
// VALUE_BITS bits. The master channel returns its decimal text, one ASCII
// character per word: a '-' first for negative values, then the digits most
// significant first without leading zeros, with tlast on the final digit.
// Zero gives the single character '0'.
//
// The block works on one value at a time. After a value is accepted, the
// double-dabble loop shifts one magnitude bit per cycle into the BCD register,
// leading zero digits are then dropped at one digit per cycle, and characters
// leave at one per cycle through the output register while the receiver does
// not stall. s_tready is high only between values.
//
// When the receiver stalls, the current character holds in the output
// register and the converter waits. Reset clears all control state; no
// output word is valid after reset.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata, // value, zero padded
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata, // character
	output logic m_tlast        // last
);
	import sida_pkg::*;

	localparam int DIGITS   = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_BITS = DIGITS * DIGIT_BITS;
	localparam int BCNT_W   = $clog2(VALUE_BITS + 1);
	localparam int DCNT_W   = $clog2(DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCNT_W-1:0]     bit_cnt_q;
	logic [DCNT_W-1:0]     dig_cnt_q;
	logic                  sign_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic [VALUE_BITS-1:0] raw;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [DIGIT_BITS-1:0] top_digit;
	logic                  slot_free;

	assign raw       = s_tdata[VALUE_BITS-1:0];
	assign top_digit = bcd_q[BCD_BITS-1 -: DIGIT_BITS];
	assign slot_free = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_char_q;
	assign m_tlast   = out_last_q;

	sida_dabble #(
		.DIGITS(DIGITS)
	) u_dabble (
		.bcd      (bcd_q),
		.adjusted (bcd_adj)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the emit state the output register is refilled below instead.
			if (out_valid_q && m_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sign_q    <= raw[VALUE_BITS-1];
						mag_q     <= raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
						bcd_q     <= '0;
						bit_cnt_q <= BCNT_W'(VALUE_BITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
					mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == BCNT_W'(1)) begin
						dig_cnt_q <= DCNT_W'(DIGITS);
						state_q   <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Drop leading zeros, but always keep the units digit.
					if (top_digit == '0 && dig_cnt_q != DCNT_W'(1)) begin
						bcd_q     <= {bcd_q[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (sign_q) begin
							out_char_q <= CHAR_MINUS;
							out_last_q <= 1'b0;
							sign_q     <= 1'b0;
						end else begin
							out_char_q <= CHAR_ZERO | {{(8-DIGIT_BITS){1'b0}}, top_digit};
							out_last_q <= (dig_cnt_q == DCNT_W'(1));
							bcd_q      <= {bcd_q[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
							dig_cnt_q  <= dig_cnt_q - 1'b1;
							if (dig_cnt_q == DCNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sim/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

	localparam int VALUE_BITS = 32;
	localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam int RANDOM_VALUES = 350;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		bit                    drain_first;
		bit                    may_idle;
	} value_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_BITS-1:0] s_tdata = '0; // value
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;                // character
	logic m_tlast;                      // last

	value_word_t values_pending[$];
	char_word_t  text_due[$];
	int          mismatches = 0;
	int          chars_seen = 0;
	int          cycles = 0;
	int          src_gap = 0;
	int          sink_stall = 0;
	int          sink_hold = 0;
	bit          hold_done = 1'b0;

	signed_int_to_decimal_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected text of one value: sign, then digits most significant first.
	function automatic void predict_text(logic [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] mag;
		logic [7:0]            digits[$];
		bit                    negative;
		char_word_t            w;
		negative = value[VALUE_BITS-1];
		mag = negative ? (~value + 1'b1) : value;
		do begin
			digits.push_front(ASCII_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (negative) begin
			w.ch = ASCII_MINUS;
			w.last = 1'b0;
			text_due.push_back(w);
		end
		foreach (digits[i]) begin
			w.ch = digits[i];
			w.last = (i == digits.size() - 1);
			text_due.push_back(w);
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 60);
	endfunction

	function automatic longint unsigned pow10(int n);
		longint unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// A value whose magnitude has a random number of decimal digits.
	function automatic logic [VALUE_BITS-1:0] value_of_length();
		int              ndig;
		bit              negative;
		longint unsigned lo, hi, mag;
		ndig = $urandom_range(1, 10);
		negative = $urandom_range(0, 1);
		lo = (ndig == 1) ? 0 : pow10(ndig - 1);
		hi = pow10(ndig) - 1;
		if (negative && hi > 64'd2147483648)
			hi = 64'd2147483648;
		if (!negative && hi > 64'd2147483647)
			hi = 64'd2147483647;
		mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		return negative ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
	endfunction

	// Values just around a power of ten, both signs.
	function automatic logic [VALUE_BITS-1:0] value_near_decade();
		longint signed v;
		v = longint'(pow10($urandom_range(0, 9))) + $signed($urandom_range(0, 2)) - 1;
		if ($urandom_range(0, 1))
			v = -v;
		return VALUE_BITS'(v);
	endfunction

	function automatic void queue_value(logic [VALUE_BITS-1:0] value, bit drain_first,
			bit may_idle);
		value_word_t item;
		item.value = value;
		item.drain_first = drain_first;
		item.may_idle = may_idle;
		values_pending.push_back(item);
	endfunction

	// Sender: one word offered at a time, held until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		bit taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else if (!(s_tvalid && !s_tready)) begin
			taken = s_tvalid && s_tready;
			if (taken)
				predict_text(s_tdata[VALUE_BITS-1:0]);
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (values_pending.size() != 0 &&
					!(values_pending[0].drain_first && text_due.size() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= DATA_BITS'(values_pending[0].value);
				src_gap <= values_pending[0].may_idle ? pick_gap() : 0;
				void'(values_pending.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks each character word and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		char_word_t want;
		bit         taken;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
			sink_hold <= 0;
		end else begin
			taken = m_tvalid && m_tready;
			if (taken) begin
				chars_seen++;
				if (text_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected character word: char=%h last=%b",
							m_tdata, m_tlast);
				end else begin
					want = text_due.pop_front();
					if (m_tdata !== want.ch || m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("character word %0d: expected char=%h last=%b, got char=%h last=%b",
								chars_seen, want.ch, want.last, m_tdata, m_tlast);
					end
				end
			end
			if (!hold_done && chars_seen >= 200) begin
				// Long hold-off so the converter backs up and refuses input.
				hold_done <= 1'b1;
				sink_hold <= LONG_HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				m_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				// Every third stretch of 300 words runs without stalls.
				if (taken && (chars_seen / 300) % 3 != 2)
					sink_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int roll;
		// Directed values: extremes, zero, digit count boundaries.
		queue_value(32'd0, 1'b0, 1'b0);
		queue_value(32'd1, 1'b0, 1'b0);
		queue_value(-32'sd1, 1'b0, 1'b0);
		queue_value(32'd9, 1'b0, 1'b0);
		queue_value(32'd10, 1'b0, 1'b0);
		queue_value(-32'sd10, 1'b0, 1'b0);
		queue_value(32'd99, 1'b0, 1'b0);
		queue_value(32'd100, 1'b0, 1'b0);
		queue_value(32'h7FFF_FFFF, 1'b0, 1'b0);
		queue_value(32'h8000_0000, 1'b0, 1'b0);
		queue_value(32'h8000_0001, 1'b0, 1'b0);
		queue_value(32'd999999999, 1'b0, 1'b0);
		queue_value(32'd1000000000, 1'b0, 1'b0);
		queue_value(-32'sd1000000000, 1'b0, 1'b0);
		queue_value(-32'sd999999999, 1'b0, 1'b0);
		queue_value(32'd1234567890, 1'b0, 1'b0);
		queue_value(-32'sd987654321, 1'b0, 1'b0);
		queue_value(32'h5555_5555, 1'b0, 1'b0);
		queue_value(32'hAAAA_AAAA, 1'b0, 1'b0);
		queue_value(32'd0, 1'b0, 1'b1);
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			roll = $urandom_range(0, 99);
			// Sender pauses for a full drain once, and idles only in some stretches.
			queue_value(roll < 55 ? value_of_length() :
				roll < 85 ? VALUE_BITS'($urandom) : value_near_decade(),
				i == 150, (i / 60) % 3 != 1);
		end

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (values_pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (text_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && text_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sida_pkg.sv
rtl/sida_dabble.sv
rtl/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_tb.sv
